@@ rtl/goi_pkg.sv @@
// Shared types, codes and constants of the grid obstacle inflation block.
package goi_pkg;

  // default sizing
  localparam int DEF_MAX_DIM  = 128;
  localparam int DEF_MAX_HALF = 15;

  // port field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int MODE_W     = 2;
  localparam int CELL_W     = 8;
  localparam int COST_W     = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FREE         = 3'd5;

  // register reset values
  localparam logic [7:0] RST_GRID_WIDTH  = 8'd128;
  localparam logic [7:0] RST_GRID_HEIGHT = 8'd128;
  localparam logic [3:0] RST_HALF_WIDTH  = 4'd5;
  localparam logic [3:0] RST_HALF_HEIGHT = 4'd5;
  localparam logic [7:0] RST_OBSTACLE    = 8'd150;
  localparam logic [7:0] RST_FREE        = 8'd0;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // cost codes
  localparam logic signed [COST_W-1:0] COST_LETHAL  = 8'sd100;
  localparam logic signed [COST_W-1:0] COST_FREE    = 8'sd0;
  localparam logic signed [COST_W-1:0] COST_UNKNOWN = -8'sd1;

  typedef struct packed {
    logic accept;       // latch incoming cell byte
    logic start_map;    // rewind positions, restart clear sweep
    logic clr_step;     // clear one lethal mark
    logic load_commit;  // write free mark, advance load position
    logic div_start;    // split load position into x and y
    logic setup;        // box limits
    logic base;         // first address of the box
    logic mark_step;    // mark one lethal cell
    logic rd_issue;     // read both mark stores
    logic out_load;     // fill the output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic load_ok;
    logic is_obst;
    logic div_done;
    logic mark_last;
    logic rd_ok;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/goi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module goi_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/goi_datapath.sv @@
// Datapath: configuration, positions, divider, box walker, mark stores, output register.
module goi_datapath
  import goi_pkg::*;
#(
  parameter int MAX_DIM  = DEF_MAX_DIM,
  parameter int MAX_HALF = DEF_MAX_HALF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [CELL_W-1:0]        cell_in,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic                     out_tready,
  output logic                     out_tvalid,
  output logic signed [COST_W-1:0] out_tdata,
  output logic                     out_tlast
);

  localparam int CELLS  = MAX_DIM * MAX_DIM;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CRD_W  = $clog2(MAX_DIM);
  localparam int HALF_W = $clog2(MAX_HALF + 1);
  localparam int SUM_W  = $clog2(MAX_DIM + MAX_HALF + 1);
  localparam int PRD_W  = 2 * DIM_W;
  localparam int BAS_W  = CRD_W + DIM_W + 1;
  localparam int DCNT_W = $clog2(IDX_W + 1);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [7:0] v);
    logic [31:0] t;
    t = 32'(v);
    if (t == 32'd0) begin
      t = 32'd1;
    end else if (t > 32'(MAX_DIM)) begin
      t = 32'(MAX_DIM);
    end
    return t[DIM_W-1:0];
  endfunction

  function automatic logic [HALF_W-1:0] clamp_half(input logic [3:0] v);
    logic [31:0] t;
    t = 32'(v);
    if (t > 32'(MAX_HALF)) begin
      t = 32'(MAX_HALF);
    end
    return t[HALF_W-1:0];
  endfunction

  // configuration
  logic [7:0] gw_r, gh_r, obst_r, free_r;
  logic [3:0] hwc_r, hhc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r   <= RST_GRID_WIDTH;
      gh_r   <= RST_GRID_HEIGHT;
      hwc_r  <= RST_HALF_WIDTH;
      hhc_r  <= RST_HALF_HEIGHT;
      obst_r <= RST_OBSTACLE;
      free_r <= RST_FREE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  gw_r   <= cfg_wdata;
        REG_GRID_HEIGHT: gh_r   <= cfg_wdata;
        REG_HALF_WIDTH:  hwc_r  <= cfg_wdata[3:0];
        REG_HALF_HEIGHT: hhc_r  <= cfg_wdata[3:0];
        REG_OBSTACLE:    obst_r <= cfg_wdata;
        REG_FREE:        free_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0]  dim_w, dim_h;
  logic [HALF_W-1:0] half_w, half_h;
  logic [PRD_W-1:0]  prod;
  logic [CNT_W-1:0]  total;

  always_comb begin
    dim_w  = clamp_dim(gw_r);
    dim_h  = clamp_dim(gh_r);
    half_w = clamp_half(hwc_r);
    half_h = clamp_half(hhc_r);
    prod   = PRD_W'(dim_w) * PRD_W'(dim_h);
    total  = prod[CNT_W-1:0];
  end

  // positions and sweep counter
  logic [CNT_W-1:0]  load_idx_r, rd_idx_r;
  logic [IDX_W-1:0]  clr_cnt_r;
  logic [CELL_W-1:0] cell_r;
  logic              rd_loaded_r, rd_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_idx_r <= '0;
      rd_idx_r   <= '0;
      clr_cnt_r  <= '0;
    end else begin
      if (cmd.start_map) begin
        load_idx_r <= '0;
        rd_idx_r   <= '0;
        clr_cnt_r  <= '0;
      end else begin
        if (cmd.clr_step) begin
          clr_cnt_r <= clr_cnt_r + IDX_W'(1);
        end
        if (cmd.load_commit) begin
          load_idx_r <= load_idx_r + CNT_W'(1);
        end
        if (cmd.rd_issue) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cell_r <= cell_in;
    end
    if (cmd.rd_issue) begin
      rd_loaded_r <= rd_idx_r < load_idx_r;
      rd_last_r   <= rd_idx_r == total - CNT_W'(1);
    end
  end

  // restoring divider: load position / grid width, one quotient bit per cycle
  logic [IDX_W-1:0]  div_quo_r;
  logic [DIM_W-1:0]  div_rem_r, rem_nxt;
  logic [DCNT_W-1:0] div_cnt_r;
  logic              div_busy_r, qbit;
  logic [DIM_W:0]    trial, diff;

  always_comb begin
    trial = {div_rem_r, div_quo_r[IDX_W-1]};
    diff  = trial - {1'b0, dim_w};
    if (trial >= {1'b0, dim_w}) begin
      qbit    = 1'b1;
      rem_nxt = diff[DIM_W-1:0];
    end else begin
      qbit    = 1'b0;
      rem_nxt = trial[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
    end else if (div_busy_r && div_cnt_r == DCNT_W'(IDX_W - 1)) begin
      div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_quo_r <= load_idx_r[IDX_W-1:0];
      div_rem_r <= '0;
      div_cnt_r <= '0;
    end else if (div_busy_r) begin
      div_quo_r <= {div_quo_r[IDX_W-2:0], qbit};
      div_rem_r <= rem_nxt;
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
  end

  // box limits, clipped at the grid edges
  logic [SUM_W-1:0] cxs, cys, hws, hhs, wss, hss;
  logic [SUM_W-1:0] x0s, x1s, y0s, y1s, steps;
  logic [CRD_W-1:0] x0_r, x1_r, y0_r, y1_r;
  logic [DIM_W-1:0] row_step_r;

  always_comb begin
    cxs   = SUM_W'(div_rem_r[CRD_W-1:0]);
    cys   = SUM_W'(div_quo_r[CRD_W-1:0]);
    hws   = SUM_W'(half_w);
    hhs   = SUM_W'(half_h);
    wss   = SUM_W'(dim_w);
    hss   = SUM_W'(dim_h);
    x0s   = (cxs > hws) ? cxs - hws : '0;
    y0s   = (cys > hhs) ? cys - hhs : '0;
    x1s   = (cxs + hws < wss) ? cxs + hws : wss - SUM_W'(1);
    y1s   = (cys + hhs < hss) ? cys + hhs : hss - SUM_W'(1);
    steps = wss - (x1s - x0s);
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      x0_r       <= x0s[CRD_W-1:0];
      x1_r       <= x1s[CRD_W-1:0];
      y0_r       <= y0s[CRD_W-1:0];
      y1_r       <= y1s[CRD_W-1:0];
      row_step_r <= steps[DIM_W-1:0];
    end
  end

  // box walker
  logic [BAS_W-1:0] base;
  logic [IDX_W-1:0] mark_addr_r;
  logic [CRD_W-1:0] mx_r, my_r;

  assign base = BAS_W'(y0_r) * BAS_W'(dim_w) + BAS_W'(x0_r);

  always_ff @(posedge clk) begin
    if (cmd.base) begin
      mark_addr_r <= base[IDX_W-1:0];
      mx_r        <= x0_r;
      my_r        <= y0_r;
    end else if (cmd.mark_step) begin
      if (mx_r == x1_r) begin
        mx_r        <= x0_r;
        my_r        <= my_r + CRD_W'(1);
        mark_addr_r <= mark_addr_r + IDX_W'(row_step_r);
      end else begin
        mx_r        <= mx_r + CRD_W'(1);
        mark_addr_r <= mark_addr_r + IDX_W'(1);
      end
    end
  end

  // mark stores
  logic             leth_we, leth_q, free_q;
  logic [IDX_W-1:0] leth_waddr;

  assign leth_we    = cmd.clr_step | cmd.mark_step;
  assign leth_waddr = cmd.clr_step ? clr_cnt_r : mark_addr_r;

  goi_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_lethal (
    .clk   (clk),
    .we    (leth_we),
    .waddr (leth_waddr),
    .wdata (cmd.mark_step),
    .re    (cmd.rd_issue),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (leth_q)
  );

  goi_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_free (
    .clk   (clk),
    .we    (cmd.load_commit),
    .waddr (load_idx_r[IDX_W-1:0]),
    .wdata (cell_r == free_r),
    .re    (cmd.rd_issue),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (free_q)
  );

  // output register
  logic                     out_valid_r, last_r;
  logic signed [COST_W-1:0] cost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      last_r <= rd_last_r;
      if (leth_q) begin
        cost_r <= COST_LETHAL;
      end else if (rd_loaded_r && free_q) begin
        cost_r <= COST_FREE;
      end else begin
        cost_r <= COST_UNKNOWN;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = cost_r;
  assign out_tlast  = last_r;

  always_comb begin
    sts.clr_last  = clr_cnt_r == IDX_W'(CELLS - 1);
    sts.load_ok   = load_idx_r < total;
    sts.is_obst   = cell_r == obst_r;
    sts.div_done  = !div_busy_r;
    sts.mark_last = (mx_r == x1_r) && (my_r == y1_r);
    sts.rd_ok     = rd_idx_r < total;
    sts.out_free  = !out_valid_r || out_tready;
  end

endmodule

@@ rtl/goi_ctrl.sv @@
// Controller: sequences clear sweeps, cell loads, box marking and cost reads.
module goi_ctrl
  import goi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic [MODE_W-1:0] mode,
  output logic              in_tready,
  input  sts_t              sts,
  output cmd_t              cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_SETUP,
    S_BASE,
    S_MARK,
    S_RD_WAIT,
    S_RD_DATA
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r;
  logic   accept;

  assign accept    = in_tvalid && in_tready_r;
  assign in_tready = in_tready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          case (mode)
            MODE_START: begin
              cmd.start_map = 1'b1;
              state_nxt     = S_CLEAR;
            end
            MODE_LOAD: state_nxt = S_LOAD;
            MODE_READ: state_nxt = S_RD_WAIT;
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        if (!sts.load_ok) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.load_commit = 1'b1;
          if (sts.is_obst) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_BASE;
      end
      S_BASE: begin
        cmd.base  = 1'b1;
        state_nxt = S_MARK;
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD_WAIT: begin
        if (!sts.rd_ok) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_RD_DATA;
        end
      end
      S_RD_DATA: begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= state_nxt == S_IDLE;
    end
  end

endmodule

@@ rtl/grid_obstacle_inflation_top.sv @@
// Top level of the grid obstacle inflation block: occupancy grid in, cost map out.
//
//   channel  direction  handshake          payload
//   in_      input      tvalid / tready    tuser: mode, tdata: cell_value
//   out_     output     tvalid / tready    tdata: cost, tlast: last_cell
//   cfg_     input      we                 index, wdata
//
// One item at a time. An obstacle cell of a load item adds a division of its
// load position by the grid width, the setup and base steps and a walk that
// marks each cell of its clipped box (11 x 11 = 121 at the default half sizes)
// in turn, as the lethal store takes one write per cycle. A read item waits
// while the output register is stalled. After reset and after every start
// item a sweep over all MAX_DIM*MAX_DIM cells clears the lethal store; no item is
// taken meanwhile, configuration writes are.
module grid_obstacle_inflation_top
  import goi_pkg::*;
#(
  parameter int MAX_DIM  = DEF_MAX_DIM,
  parameter int MAX_HALF = DEF_MAX_HALF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CELL_W-1:0]     in_tdata,   // [7:0] cell_value
  input  logic [MODE_W-1:0]     in_tuser,   // [1:0] mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [COST_W-1:0]     out_tdata,  // [7:0] cost
  output logic                  out_tlast
);

  cmd_t                     cmd;
  sts_t                     sts;
  logic signed [COST_W-1:0] cost;

  goi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .mode      (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  goi_datapath #(
    .MAX_DIM  (MAX_DIM),
    .MAX_HALF (MAX_HALF)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cell_in    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (cost),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = cost;

endmodule

@@ rtl/goi_checker.sv @@
// Port-level checks of the grid obstacle inflation block, bound to the top level.
module goi_checker
  import goi_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [CELL_W-1:0]     in_tdata,
  input logic [MODE_W-1:0]     in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [COST_W-1:0]     out_tdata,
  input logic                  out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // only the three cost codes leave the block
  a_cost_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == COST_LETHAL || out_tdata == COST_FREE ||
                    out_tdata == COST_UNKNOWN))
    else $error("cost outside its codes");

  // the clear sweep follows reset, so no item is taken straight after it
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("item taken during clear after reset");

  // every item of a used kind keeps the block busy, so in_tready drops after it is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != MODE_UNUSED |=> !in_tready)
    else $error("item taken while previous one still at work");

  // a result appears only at the end of a read, never from idle
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without a read in progress");

endmodule

bind grid_obstacle_inflation_top goi_checker u_goi_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench of the grid obstacle inflation block: random maps against a cost-map predictor.
`timescale 1ns / 100ps

module testbench;
  import goi_pkg::*;

  localparam int GRID_MAX       = DEF_MAX_DIM;
  localparam int GRID_CELLS     = DEF_MAX_DIM * DEF_MAX_DIM;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int SETTLE_CYCLES  = 1200;   // divider, setup and a full 31 x 31 box
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 80000;  // covers a full clearing sweep several times
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CELL_W-1:0] cell_byte;
  } grid_item_t;

  typedef struct packed {
    logic signed [COST_W-1:0] cost;
    logic                     last;
  } cell_cost_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [CELL_W-1:0]     in_tdata = '0;   // [7:0] cell_value
  logic [MODE_W-1:0]     in_tuser = '0;   // [1:0] mode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [COST_W-1:0]     out_tdata;       // [7:0] cost
  logic                  out_tlast;

  grid_obstacle_inflation_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow
  logic [7:0] reg_width    = RST_GRID_WIDTH;
  logic [7:0] reg_height   = RST_GRID_HEIGHT;
  logic [3:0] reg_half_w   = RST_HALF_WIDTH;
  logic [3:0] reg_half_h   = RST_HALF_HEIGHT;
  logic [7:0] reg_obstacle = RST_OBSTACLE;
  logic [7:0] reg_free     = RST_FREE;

  // cost map state
  bit          lethal_map [GRID_CELLS];
  bit          free_map   [GRID_CELLS];
  int unsigned load_pos = 0;
  int unsigned read_pos = 0;

  grid_item_t  pending_cells [$];
  cell_cost_t  expected_costs [$];
  int          n_queued = 0;
  int          n_accepted = 0;
  int          n_costs = 0;
  int          n_errors = 0;
  int          n_useful = 0;

  grid_item_t  tx_item;
  int          tx_gap = 0;
  bit          tx_steady = 1'b0;
  int          rx_wait = 0;
  int          rx_hold = 0;
  bit          rx_steady = 1'b0;
  int          quiet_cycles = 0;

  function automatic int unsigned eff_dim(logic [7:0] v);
    if (v == 8'd0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return 32'(v);
  endfunction

  function automatic int unsigned pick_wait(bit steady);
    if (steady) return 0;
    return $urandom_range(12, 0);
  endfunction

  function automatic void note_error(string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // Apply one accepted item to the cost map; a read of a valid cell yields one cost.
  function automatic void update_cost_map(logic [MODE_W-1:0] mode,
                                          logic [CELL_W-1:0] cell_byte);
    int unsigned w, h, total, cx, cy, hw, hh, x0, x1, y0, y1;
    cell_cost_t res;
    w  = eff_dim(reg_width);
    h  = eff_dim(reg_height);
    hw = (reg_half_w > DEF_MAX_HALF) ? DEF_MAX_HALF : 32'(reg_half_w);
    hh = (reg_half_h > DEF_MAX_HALF) ? DEF_MAX_HALF : 32'(reg_half_h);
    total = w * h;
    case (mode)
      MODE_START: begin
        foreach (lethal_map[i]) lethal_map[i] = 1'b0;
        load_pos = 0;
        read_pos = 0;
      end
      MODE_LOAD: begin
        if (load_pos < total) begin
          if (cell_byte == reg_obstacle) begin
            cx = load_pos % w;
            cy = load_pos / w;
            x0 = (cx > hw) ? cx - hw : 0;
            y0 = (cy > hh) ? cy - hh : 0;
            x1 = (cx + hw < w) ? cx + hw : w - 1;
            y1 = (cy + hh < h) ? cy + hh : h - 1;
            for (int y = y0; y <= y1; y++)
              for (int x = x0; x <= x1; x++)
                lethal_map[y * w + x] = 1'b1;
          end
          free_map[load_pos] = (cell_byte == reg_free);
          load_pos++;
        end
      end
      MODE_READ: begin
        if (read_pos < total) begin
          if (lethal_map[read_pos]) res.cost = COST_LETHAL;
          else if (read_pos < load_pos && free_map[read_pos]) res.cost = COST_FREE;
          else res.cost = COST_UNKNOWN;
          res.last = (read_pos == total - 1);
          expected_costs.push_back(res);
          read_pos++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_cost(logic [COST_W-1:0] got_cost, logic got_last);
    cell_cost_t want;
    if (expected_costs.size() == 0) begin
      note_error($sformatf("unexpected cost item: cost %0d last %0b",
                           $signed(got_cost), got_last));
      return;
    end
    want = expected_costs.pop_front();
    if (got_cost !== want.cost)
      note_error($sformatf("cost mismatch: expected %0d got %0d",
                           $signed(want.cost), $signed(got_cost)));
    if (got_last !== want.last)
      note_error($sformatf("last_cell mismatch: expected %0b got %0b", want.last, got_last));
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        update_cost_map(in_tuser, in_tdata);
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_cells.size() != 0) begin
          tx_item = pending_cells.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= tx_item.mode;
          in_tdata  <= tx_item.cell_byte;
          if ($urandom_range(39, 0) == 0) tx_steady = !tx_steady;
          tx_gap = pick_wait(tx_steady);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor; twice in the run the receiver holds off long enough to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
      rx_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_cost(out_tdata, out_tlast);
        n_costs++;
        if (n_costs == 60 || n_costs == 500) rx_hold = HOLD_CYCLES;
        if ($urandom_range(39, 0) == 0) rx_steady = !rx_steady;
        rx_wait = pick_wait(rx_steady);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_GRID_WIDTH:  reg_width    = val;
      REG_GRID_HEIGHT: reg_height   = val;
      REG_HALF_WIDTH:  reg_half_w   = val[3:0];
      REG_HALF_HEIGHT: reg_half_h   = val[3:0];
      REG_OBSTACLE:    reg_obstacle = val;
      REG_FREE:        reg_free     = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [7:0] w, input logic [7:0] h, input logic [7:0] hw,
                           input logic [7:0] hh, input logic [7:0] obst,
                           input logic [7:0] free_val);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_HALF_WIDTH, hw);
    write_reg(REG_HALF_HEIGHT, hh);
    write_reg(REG_OBSTACLE, obst);
    write_reg(REG_FREE, free_val);
  endtask

  // all items taken, all costs drained, then let a pending box finish
  task automatic wait_idle();
    while (n_accepted != n_queued || expected_costs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_item(input logic [MODE_W-1:0] mode, input logic [CELL_W-1:0] cell_byte);
    grid_item_t it;
    it.mode      = mode;
    it.cell_byte = cell_byte;
    pending_cells.push_back(it);
    n_queued++;
    if (mode != MODE_UNUSED) n_useful++;
  endtask

  function automatic logic [3:0] pick_half();
    case ($urandom_range(3, 0))
      0:       return 4'd0;
      1:       return 4'd15;
      default: return 4'($urandom_range(15, 0));
    endcase
  endfunction

  function automatic logic [7:0] pick_cell();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 15) return reg_obstacle;
    if (r < 60) return reg_free;
    return 8'($urandom_range(255, 0));
  endfunction

  task automatic random_setup();
    logic [7:0] w, h, obst, free_val;
    if ($urandom_range(9, 0) == 0) begin
      case ($urandom_range(3, 0))
        0:       begin w = 8'd128; h = 8'($urandom_range(2, 1)); end
        1:       begin w = 8'($urandom_range(255, 129)); h = 8'd1; end   // acts as full width
        2:       begin w = 8'($urandom_range(12, 1)); h = 8'd0; end      // acts as one row
        default: begin w = 8'd1; h = 8'd128; end
      endcase
    end else begin
      w = 8'($urandom_range(12, 1));
      h = 8'($urandom_range(12, 1));
    end
    obst = 8'($urandom_range(255, 0));
    free_val = ($urandom_range(7, 0) == 0) ? obst : 8'($urandom_range(255, 0));
    write_all(w, h, {4'd0, pick_half()}, {4'd0, pick_half()}, obst, free_val);
  endtask

  // The base plan is a clean start / load all / read all; some maps overrun, stop short,
  // interleave reads with loads, skip the start or carry unused-mode noise.
  task automatic random_map();
    int unsigned total, n_load, n_read;
    bit mixed, pick_load;
    total = eff_dim(reg_width) * eff_dim(reg_height);
    if ($urandom_range(9, 0) != 0) push_item(MODE_START, 8'($urandom_range(255, 0)));
    n_load = total;
    n_read = total;
    case ($urandom_range(7, 0))
      0: n_load = total + $urandom_range(3, 1);
      1: n_load = $urandom_range(total, 0);
      2: n_read = total + $urandom_range(3, 1);
      3: n_read = $urandom_range(total, 0);
      default: ;
    endcase
    mixed = ($urandom_range(4, 0) == 0);
    while (n_load > 0 || n_read > 0) begin
      if ($urandom_range(39, 0) == 0) push_item(MODE_UNUSED, 8'($urandom_range(255, 0)));
      if (n_load == 0) pick_load = 1'b0;
      else if (n_read == 0 || !mixed) pick_load = 1'b1;
      else pick_load = 1'($urandom_range(1, 0));
      if (pick_load) begin
        push_item(MODE_LOAD, pick_cell());
        n_load--;
      end else begin
        push_item(MODE_READ, 8'($urandom_range(255, 0)));
        n_read--;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero width acts as one column; read before load, full grid, unused mode, read past end
    write_all(8'd0, 8'd3, 8'd15, 8'd0, 8'd255, 8'd0);
    push_item(MODE_START, 8'hA5);
    push_item(MODE_READ, 8'h00);
    push_item(MODE_LOAD, 8'd255);
    push_item(MODE_LOAD, 8'd0);
    push_item(MODE_LOAD, 8'd7);
    push_item(MODE_LOAD, 8'd9);
    push_item(MODE_UNUSED, 8'hFF);
    push_item(MODE_READ, 8'hFF);
    push_item(MODE_READ, 8'h5A);
    push_item(MODE_READ, 8'h00);
    wait_idle();

    // oversized width clamps to the full row
    write_all(8'd255, 8'd1, 8'd0, 8'd15, 8'd0, 8'd255);
    push_item(MODE_START, 8'h00);
    push_item(MODE_LOAD, 8'd0);
    push_item(MODE_LOAD, 8'd255);
    push_item(MODE_LOAD, 8'd128);
    push_item(MODE_READ, 8'h00);
    push_item(MODE_READ, 8'h00);
    push_item(MODE_READ, 8'h00);
    wait_idle();

    // geometry change mid-map, positions kept
    write_reg(REG_GRID_WIDTH, 8'd2);
    write_reg(REG_GRID_HEIGHT, 8'd2);
    push_item(MODE_LOAD, 8'd0);
    push_item(MODE_READ, 8'h00);
    push_item(MODE_READ, 8'h00);
    wait_idle();

    random_setup();
    n_useful = 0;
    while (n_useful < RANDOM_ITEMS) begin
      if ($urandom_range(2, 0) != 0) begin
        wait_idle();
        random_setup();
      end
      random_map();
    end

    while (n_accepted != n_queued || expected_costs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
